>>> src/ps2mpd_pkg.sv
package ps2mpd_pkg;

  // event kinds
  localparam logic [1:0] KIND_REL = 2'd0;
  localparam logic [1:0] KIND_BTN = 2'd1;
  localparam logic [1:0] KIND_SYN = 2'd2;

  // event codes
  localparam logic [2:0] CODE_X      = 3'd0;
  localparam logic [2:0] CODE_Y      = 3'd1;
  localparam logic [2:0] CODE_WHEEL  = 3'd2;
  localparam logic [2:0] CODE_LEFT   = 3'd3;
  localparam logic [2:0] CODE_RIGHT  = 3'd4;
  localparam logic [2:0] CODE_MIDDLE = 3'd5;
  localparam logic [2:0] CODE_NONE   = 3'd0;

  // positions in the pending-event mask, in emission order
  localparam int unsigned EV_X     = 0;
  localparam int unsigned EV_Y     = 1;
  localparam int unsigned EV_LEFT  = 2;
  localparam int unsigned EV_RIGHT = 3;
  localparam int unsigned EV_MID   = 4;
  localparam int unsigned EV_WHEEL = 5;
  localparam int unsigned EV_SYN   = 6;
  localparam int unsigned NUM_EV   = 7;

  // header byte bits
  localparam int unsigned HDR_SYNC_BIT = 3;
  localparam int unsigned HDR_XS_BIT   = 4;
  localparam int unsigned HDR_YS_BIT   = 5;

  // packet queue depth between front and back
  localparam int unsigned QUEUE_DEPTH = 2;
  localparam int unsigned QPTR_W      = $clog2(QUEUE_DEPTH);

  // decoded packet handed from front to back
  typedef struct packed {
    logic [2:0]        buttons;   // bit 0 left, bit 1 right, bit 2 middle
    logic signed [8:0] dx;
    logic signed [9:0] ndy;       // y motion already negated
    logic signed [3:0] wheel;
    logic              wheel_en;
  } pkt_t;

  // queue status seen by both sides
  typedef struct packed {
    logic full;
    logic empty;
  } q_status_t;

endpackage

>>> src/ps2mpd_front.sv
module ps2mpd_front
  import ps2mpd_pkg::*;
(
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       cfg_we_i,
  input  logic       cfg_wdata_i,
  input  logic       s_axis_tvalid,
  output logic       s_axis_tready,
  input  logic [7:0] s_axis_tdata,   // mouse_byte
  input  q_status_t  q_status_i,
  output logic       push_o,
  output pkt_t       push_pkt_o
);

  logic       wheel_mode_q;
  logic [1:0] idx_q, idx_d;
  logic [7:0] pb_q [3];
  logic       accept;
  logic [1:0] last_pos;
  logic [7:0] b0, b1, b2;

  // wheel mode register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wheel_mode_q <= 1'b0;
    end else if (cfg_we_i) begin
      wheel_mode_q <= cfg_wdata_i;
    end
  end

  assign s_axis_tready = !q_status_i.full;
  assign accept        = s_axis_tvalid && s_axis_tready;
  assign last_pos      = wheel_mode_q ? 2'd3 : 2'd2;

  // framing control
  always_comb begin
    idx_d  = idx_q;
    push_o = 1'b0;
    if (accept) begin
      if (idx_q == 2'd0 && !s_axis_tdata[HDR_SYNC_BIT]) begin
        idx_d = 2'd0;
      end else if (idx_q > last_pos) begin
        idx_d = 2'd0;
      end else if (idx_q == last_pos) begin
        idx_d  = 2'd0;
        push_o = (pb_q[0][7:6] == 2'b00);
      end else begin
        idx_d = idx_q + 2'd1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      idx_q <= 2'd0;
    end else begin
      idx_q <= idx_d;
    end
  end

  // packet byte store
  always_ff @(posedge clk_i) begin
    if (accept && idx_q < last_pos && !(idx_q == 2'd0 && !s_axis_tdata[HDR_SYNC_BIT])) begin
      pb_q[idx_q] <= s_axis_tdata;
    end
  end

  // decode the completed packet
  assign b0 = pb_q[0];
  assign b1 = pb_q[1];
  assign b2 = wheel_mode_q ? pb_q[2] : s_axis_tdata;

  always_comb begin
    push_pkt_o.buttons  = b0[2:0];
    push_pkt_o.dx       = {b0[HDR_XS_BIT], b1};
    push_pkt_o.ndy      = 10'sd0 - {b0[HDR_YS_BIT], b0[HDR_YS_BIT], b2};
    push_pkt_o.wheel    = s_axis_tdata[3:0];
    push_pkt_o.wheel_en = wheel_mode_q;
  end

endmodule

>>> src/ps2mpd_fifo.sv
module ps2mpd_fifo
  import ps2mpd_pkg::*;
(
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      push_i,
  input  pkt_t      push_pkt_i,
  input  logic      pop_i,
  output pkt_t      head_o,
  output q_status_t status_o
);

  pkt_t                 mem_q [QUEUE_DEPTH];
  logic [QPTR_W-1:0]    wptr_q, rptr_q;
  logic [QPTR_W:0]      cnt_q;

  assign status_o.full  = (cnt_q == (QPTR_W+1)'(QUEUE_DEPTH));
  assign status_o.empty = (cnt_q == '0);
  assign head_o         = mem_q[rptr_q];

  // pointers and fill count
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q <= '0;
      rptr_q <= '0;
      cnt_q  <= '0;
    end else begin
      if (push_i) begin
        wptr_q <= (wptr_q == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : wptr_q + 1'b1;
      end
      if (pop_i) begin
        rptr_q <= (rptr_q == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : rptr_q + 1'b1;
      end
      cnt_q <= cnt_q + (QPTR_W+1)'(push_i) - (QPTR_W+1)'(pop_i);
    end
  end

  // entry storage
  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wptr_q] <= push_pkt_i;
    end
  end

  // no push into a full queue, no pop from an empty one
  a_no_overrun: assert property (@(posedge clk_i) disable iff (!rst_ni)
    push_i |-> !status_o.full) else $error("push into full queue");
  a_no_underrun: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pop_i |-> !status_o.empty) else $error("pop from empty queue");

endmodule

>>> src/ps2mpd_back.sv
module ps2mpd_back
  import ps2mpd_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  pkt_t        head_i,
  input  q_status_t   q_status_i,
  output logic        pop_o,
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [15:0] m_axis_tdata,  // event_kind[1:0], event_code[4:2], event_value[14:5]
  output logic        m_axis_tlast   // last_of_packet
);

  pkt_t              pkt_q;
  logic [NUM_EV-1:0] mask_q, mask_d, sel;
  logic [2:0]        prev_btn_q;
  logic              ovalid_q, olast_q;
  logic [1:0]        okind_q, kind;
  logic [2:0]        ocode_q, code;
  logic [9:0]        oval_q, val;
  logic              emit, found;

  assign pop_o = (mask_q == '0) && !q_status_i.empty;
  assign emit  = (mask_q != '0) && (!ovalid_q || m_axis_tready);

  // pick the lowest pending event
  always_comb begin
    sel   = '0;
    found = 1'b0;
    for (int i = 0; i < NUM_EV; i++) begin
      if (mask_q[i] && !found) begin
        sel[i] = 1'b1;
        found  = 1'b1;
      end
    end
  end

  // event fields for the selected slot
  always_comb begin
    kind = KIND_REL;
    code = CODE_NONE;
    val  = '0;
    if (sel[EV_X]) begin
      code = CODE_X;
      val  = {pkt_q.dx[8], pkt_q.dx};
    end else if (sel[EV_Y]) begin
      code = CODE_Y;
      val  = pkt_q.ndy;
    end else if (sel[EV_LEFT]) begin
      kind = KIND_BTN;
      code = CODE_LEFT;
      val  = {9'd0, pkt_q.buttons[0]};
    end else if (sel[EV_RIGHT]) begin
      kind = KIND_BTN;
      code = CODE_RIGHT;
      val  = {9'd0, pkt_q.buttons[1]};
    end else if (sel[EV_MID]) begin
      kind = KIND_BTN;
      code = CODE_MIDDLE;
      val  = {9'd0, pkt_q.buttons[2]};
    end else if (sel[EV_WHEEL]) begin
      code = CODE_WHEEL;
      val  = {{6{pkt_q.wheel[3]}}, pkt_q.wheel};
    end else begin
      kind = KIND_SYN;
    end
  end

  // pending mask: load a packet when idle, retire one event per emit
  always_comb begin
    mask_d = mask_q;
    if (pop_o) begin
      mask_d[EV_X]     = 1'b1;
      mask_d[EV_Y]     = 1'b1;
      mask_d[EV_LEFT]  = head_i.buttons[0] ^ prev_btn_q[0];
      mask_d[EV_RIGHT] = head_i.buttons[1] ^ prev_btn_q[1];
      mask_d[EV_MID]   = head_i.buttons[2] ^ prev_btn_q[2];
      mask_d[EV_WHEEL] = head_i.wheel_en && (head_i.wheel != 4'sd0);
      mask_d[EV_SYN]   = 1'b1;
    end else if (emit) begin
      mask_d = mask_q & ~sel;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mask_q     <= '0;
      prev_btn_q <= 3'b000;
      ovalid_q   <= 1'b0;
    end else begin
      mask_q <= mask_d;
      if (pop_o) begin
        prev_btn_q <= head_i.buttons;
      end
      if (emit) begin
        ovalid_q <= 1'b1;
      end else if (m_axis_tready) begin
        ovalid_q <= 1'b0;
      end
    end
  end

  // packet and output payload
  always_ff @(posedge clk_i) begin
    if (pop_o) begin
      pkt_q <= head_i;
    end
    if (emit) begin
      okind_q <= kind;
      ocode_q <= code;
      oval_q  <= val;
      olast_q <= sel[EV_SYN];
    end
  end

  assign m_axis_tvalid = ovalid_q;
  assign m_axis_tdata  = {1'b0, oval_q, ocode_q, okind_q};
  assign m_axis_tlast  = olast_q;

  // a pending run always ends in its sync event
  a_sync_pending: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (mask_q != '0) |-> mask_q[EV_SYN]) else $error("pending run lacks sync");
  // emitting the sync closes the run
  a_sync_closes: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (emit && sel[EV_SYN]) |=> (mask_q == '0)) else $error("run not closed by sync");
  // a new packet is loaded only when no run is pending
  a_load_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pop_o |-> !emit) else $error("load during active run");

endmodule

>>> src/ps2_mouse_packet_decoder.sv
// PS/2 mouse packet decoder. Each received mouse byte is accepted
// whenever the two-packet queue has room; the front frames 3-byte packets
// (4-byte with wheel_mode set), drops bytes until a header with bit 3 set,
// and drops packets with an overflow bit. The back turns each queued packet
// into 3 to 7 events (x, negated y, changed buttons, nonzero wheel, sync with
// tlast) at one event per cycle unless the output stalls, after loading the
// packet, and it loads the next only after the sync; output stalls back up
// into the queue and, once it holds two packets, hold off the input. Write
// wheel_mode only while no packet is in flight.
module ps2_mouse_packet_decoder
  import ps2mpd_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic        cfg_wdata_i,    // wheel_mode
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [7:0]  s_axis_tdata,   // mouse_byte[7:0]
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [15:0] m_axis_tdata,   // event_kind[1:0], event_code[4:2], event_value[14:5]
  output logic        m_axis_tlast    // last_of_packet
);

  q_status_t q_status;
  logic      push, pop;
  pkt_t      push_pkt, head;

  ps2mpd_front u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_we_i     (cfg_we_i),
    .cfg_wdata_i  (cfg_wdata_i),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),
    .q_status_i   (q_status),
    .push_o       (push),
    .push_pkt_o   (push_pkt)
  );

  ps2mpd_fifo u_fifo (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .push_i    (push),
    .push_pkt_i(push_pkt),
    .pop_i     (pop),
    .head_o    (head),
    .status_o  (q_status)
  );

  ps2mpd_back u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .head_i       (head),
    .q_status_i   (q_status),
    .pop_o        (pop),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata),
    .m_axis_tlast (m_axis_tlast)
  );

endmodule

>>> test/tb_ps2_mouse_packet_decoder.sv
module tb_ps2_mouse_packet_decoder;
  import ps2mpd_pkg::*;

  localparam int RANDOM_ITEMS   = 300;
  localparam int QUIET_ITEMS    = 60;
  localparam int SETTLE_CYCLES  = 16;
  localparam int WATCHDOG_LIMIT = 2000;
  localparam int NUM_ROWS       = 30;

  // header overflow bits
  localparam int unsigned OVF_X_BIT = 6;
  localparam int unsigned OVF_Y_BIT = 7;

  // button codes, left in the low slice
  localparam logic [8:0] BUTTON_CODES = {CODE_MIDDLE, CODE_RIGHT, CODE_LEFT};

  typedef struct packed {
    logic [1:0]        kind;
    logic [2:0]        code;
    logic signed [9:0] value;
    logic              last;
  } mouse_ev_t;

  typedef enum logic {ROW_BYTE, ROW_MODE} row_op_e;

  typedef struct packed {
    row_op_e    op;
    logic [7:0] value;
    int         n_events;   // -1 where only the predictor decides
  } step_t;

  logic        clk_i;
  logic        rst_ni;
  logic        cfg_we_i;
  logic        cfg_wdata_i;
  logic        s_axis_tvalid;
  logic        s_axis_tready;
  logic [7:0]  s_axis_tdata;    // mouse_byte[7:0]
  logic        m_axis_tvalid;
  logic        m_axis_tready;
  logic [15:0] m_axis_tdata;    // event_kind[1:0], event_code[4:2], event_value[14:5]
  logic        m_axis_tlast;    // last_of_packet

  // decoder mirror state
  logic       wheel_on     = 1'b0;
  logic [1:0] frame_pos    = 2'd0;
  logic [7:0] pkt_store [3];
  logic [2:0] held_buttons = 3'd0;

  mouse_ev_t pending_events [$];
  int        fail_count = 0;
  bit        tx_gaps    = 1'b1;
  bit        rx_stalls  = 1'b1;

  // directed stimulus
  step_t directed_steps [NUM_ROWS] = '{
    // after reset: largest positive motion, no buttons
    '{ROW_BYTE, 8'h08, -1}, '{ROW_BYTE, 8'hFF, -1}, '{ROW_BYTE, 8'hFF, 3},
    // header without sync bit is dropped
    '{ROW_BYTE, 8'h07, 0},
    // most negative motion, all buttons pressed
    '{ROW_BYTE, 8'h3F, -1}, '{ROW_BYTE, 8'h00, -1}, '{ROW_BYTE, 8'h00, 6},
    // x overflow drops the packet, buttons kept
    '{ROW_BYTE, 8'h4F, -1}, '{ROW_BYTE, 8'h11, -1}, '{ROW_BYTE, 8'h22, 0},
    // wheel packets: top positive nibble, then most negative with every button changing
    '{ROW_MODE, 8'h01, -1},
    '{ROW_BYTE, 8'h09, -1}, '{ROW_BYTE, 8'h10, -1}, '{ROW_BYTE, 8'h20, -1},
    '{ROW_BYTE, 8'h07, 6},
    '{ROW_BYTE, 8'h0E, -1}, '{ROW_BYTE, 8'h01, -1}, '{ROW_BYTE, 8'h01, -1},
    '{ROW_BYTE, 8'h08, 7},
    // wheel mode raised mid-packet, zero wheel nibble
    '{ROW_MODE, 8'h00, -1},
    '{ROW_BYTE, 8'h08, -1}, '{ROW_BYTE, 8'h01, -1}, '{ROW_MODE, 8'h01, -1},
    '{ROW_BYTE, 8'h02, -1}, '{ROW_BYTE, 8'hF0, 5},
    // wheel mode lowered with three bytes framed
    '{ROW_BYTE, 8'h08, -1}, '{ROW_BYTE, 8'h05, -1}, '{ROW_BYTE, 8'h06, -1},
    '{ROW_MODE, 8'h00, -1}, '{ROW_BYTE, 8'h33, 0}
  };

  ps2_mouse_packet_decoder dut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_we_i     (cfg_we_i),
    .cfg_wdata_i  (cfg_wdata_i),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata),
    .m_axis_tlast (m_axis_tlast)
  );

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  function automatic void add_event(logic [1:0] kind, logic [2:0] code, logic [9:0] value,
                                    logic last);
    pending_events.push_back('{kind, code, value, last});
  endfunction

  // events of a completed packet
  function automatic void predict_packet(input logic [7:0] final_byte);
    logic [7:0] hdr;
    logic [7:0] xb;
    logic [7:0] yb;
    logic [3:0] nib;
    int         dx;
    int         dy;
    int         i;
    hdr = pkt_store[0];
    xb  = pkt_store[1];
    yb  = wheel_on ? pkt_store[2] : final_byte;
    if (hdr[OVF_X_BIT] || hdr[OVF_Y_BIT]) return;
    dx = int'(xb) - (hdr[HDR_XS_BIT] ? 256 : 0);
    dy = int'(yb) - (hdr[HDR_YS_BIT] ? 256 : 0);
    add_event(KIND_REL, CODE_X, 10'(dx), 1'b0);
    add_event(KIND_REL, CODE_Y, 10'(-dy), 1'b0);
    for (i = 0; i < 3; i++) begin
      if (hdr[i] != held_buttons[i]) begin
        add_event(KIND_BTN, BUTTON_CODES[3*i +: 3], {9'd0, hdr[i]}, 1'b0);
      end
    end
    held_buttons = hdr[2:0];
    if (wheel_on) begin
      nib = final_byte[3:0];
      if (nib != 4'd0) add_event(KIND_REL, CODE_WHEEL, {{6{nib[3]}}, nib}, 1'b0);
    end
    add_event(KIND_SYN, CODE_NONE, 10'd0, 1'b1);
  endfunction

  // packet framing of one accepted byte
  function automatic void frame_byte(input logic [7:0] b);
    logic [1:0] last_pos;
    last_pos = wheel_on ? 2'd3 : 2'd2;
    if (frame_pos == 2'd0 && !b[HDR_SYNC_BIT]) return;
    if (frame_pos > last_pos) begin
      frame_pos = 2'd0;
      return;
    end
    if (frame_pos == last_pos) begin
      frame_pos = 2'd0;
      predict_packet(b);
      return;
    end
    pkt_store[frame_pos] = b;
    frame_pos = frame_pos + 2'd1;
  endfunction

  // one byte request, with an optional idle burst first
  task automatic push_byte(input logic [7:0] b, output int produced);
    int queued;
    if (tx_gaps && $urandom_range(0, 2) == 0) begin
      s_axis_tvalid <= 1'b0;
      repeat ($urandom_range(1, 9)) @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= b;
    @(posedge clk_i);
    while (!s_axis_tready) @(posedge clk_i);
    queued = pending_events.size();
    frame_byte(b);
    produced = pending_events.size() - queued;
  endtask

  task automatic wait_drained();
    s_axis_tvalid <= 1'b0;
    while (pending_events.size() != 0) @(posedge clk_i);
  endtask

  // mode write once nothing is in flight
  task automatic write_mode(input logic mode);
    wait_drained();
    repeat (SETTLE_CYCLES) @(posedge clk_i);
    cfg_we_i    <= 1'b1;
    cfg_wdata_i <= mode;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    wheel_on = mode;
  endtask

  // mostly well-formed packets, some noise, overflow and truncation
  task automatic send_random_packet(output int n_counted);
    logic [7:0] hdr;
    int         pick;
    int         len;
    int         produced;
    int         i;
    pick      = $urandom_range(0, 19);
    n_counted = 0;
    if (pick == 0) begin
      push_byte(8'($urandom), produced);
      n_counted = 1;
      return;
    end
    hdr = 8'($urandom);
    hdr[HDR_SYNC_BIT] = 1'b1;
    if (pick > 3) begin
      hdr[OVF_X_BIT] = 1'b0;
      hdr[OVF_Y_BIT] = 1'b0;
    end
    len = wheel_on ? 4 : 3;
    if (pick == 1) len = $urandom_range(1, len - 1);
    push_byte(hdr, produced);
    for (i = 1; i < len; i++) push_byte(8'($urandom), produced);
    n_counted = len;
  endtask

  function automatic void check_field(string name, int want, int got);
    if (want != got) begin
      $display("%0t: %s expected %0d got %0d", $time, name, want, got);
      fail_count++;
    end
  endfunction

  // event checker
  always @(posedge clk_i) begin
    mouse_ev_t want;
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      if (pending_events.size() == 0) begin
        $display("%0t: event request expected none got tdata %h tlast %b",
                 $time, m_axis_tdata, m_axis_tlast);
        fail_count++;
      end else begin
        want = pending_events.pop_front();
        check_field("event kind", want.kind, m_axis_tdata[1:0]);
        check_field("event code", want.code, m_axis_tdata[4:2]);
        check_field("event value", $signed(want.value), $signed(m_axis_tdata[14:5]));
        check_field("last of packet", want.last, m_axis_tlast);
      end
    end
  end

  // receiver backpressure
  initial begin
    m_axis_tready <= 1'b1;
    forever begin
      @(posedge clk_i);
      if (rx_stalls && $urandom_range(0, 4) == 0) begin
        m_axis_tready <= 1'b0;
        repeat ($urandom_range(1, 9)) @(posedge clk_i);
        m_axis_tready <= 1'b1;
      end
    end
  end

  // watchdog on cycles with no request moving
  initial begin
    int quiet_cycles;
    quiet_cycles = 0;
    while (quiet_cycles < WATCHDOG_LIMIT) begin
      @(posedge clk_i);
      if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) begin
        quiet_cycles = 0;
      end else begin
        quiet_cycles++;
      end
    end
    $display("TEST FAILED");
    $finish;
  end

  // main sequence
  initial begin
    int produced;
    int sent;
    int phase_end;
    int r;
    rst_ni        <= 1'b0;
    cfg_we_i      <= 1'b0;
    cfg_wdata_i   <= 1'b0;
    s_axis_tvalid <= 1'b0;
    s_axis_tdata  <= 8'h00;
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // directed table
    for (r = 0; r < NUM_ROWS; r++) begin
      if (directed_steps[r].op == ROW_MODE) begin
        write_mode(directed_steps[r].value[0]);
      end else begin
        push_byte(directed_steps[r].value, produced);
        if (directed_steps[r].n_events >= 0 && produced != directed_steps[r].n_events) begin
          $display("%0t: row %0d events expected %0d got %0d",
                   $time, r, directed_steps[r].n_events, produced);
          fail_count++;
        end
      end
    end

    // random phases, each under its own wheel mode; the last one runs to the end
    sent = 0;
    while (sent < RANDOM_ITEMS) begin
      tx_gaps   = $urandom_range(0, 3) != 0;
      rx_stalls = $urandom_range(0, 3) != 0;
      write_mode(1'($urandom_range(0, 1)));
      phase_end = sent + $urandom_range(20, 60);
      if (phase_end >= RANDOM_ITEMS - QUIET_ITEMS) phase_end = RANDOM_ITEMS;
      while (sent < phase_end && sent < RANDOM_ITEMS) begin
        if (sent >= RANDOM_ITEMS - QUIET_ITEMS) begin
          tx_gaps   = 1'b0;
          rx_stalls = 1'b0;
        end
        send_random_packet(produced);
        sent += produced;
      end
    end

    wait_drained();
    repeat (SETTLE_CYCLES) @(posedge clk_i);
    if (fail_count == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule
